/* sv/uuenc_pkg.sv */
// shared types, constants and character mapping for the uuencode line encoder
// no dependencies; used by every module of the block
package uuenc_pkg;

	localparam int MAX_LINE_BYTES = 45;
	localparam int LEN_W = 6;
	localparam int SUM_W = 16;
	localparam int CHAR_W = 7;
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam int NSTEP = 6;
	localparam int STEP_W = $clog2(NSTEP);

	localparam logic [CHAR_W-1:0] CHAR_OFFSET = 7'd32;
	localparam logic [CHAR_W-1:0] ZERO_CHAR = 7'h60;
	localparam logic [CHAR_W-1:0] CR_CHAR = 7'd13;

	localparam logic [STEP_W-1:0] STEP_LEN = 3'd0;
	localparam logic [STEP_W-1:0] STEP_G0 = 3'd1;
	localparam logic [STEP_W-1:0] STEP_G1 = 3'd2;
	localparam logic [STEP_W-1:0] STEP_G2 = 3'd3;
	localparam logic [STEP_W-1:0] STEP_G3 = 3'd4;
	localparam logic [STEP_W-1:0] STEP_CR = 3'd5;

	localparam logic FUNC_ENCODE = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	typedef struct packed {
		logic             func;
		logic [7:0]       data_byte;
		logic [LEN_W-1:0] line_length;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last_in_run;
		logic [SUM_W-1:0]  checksum;
	} out_item_t;

	typedef struct packed {
		logic             has_len;
		logic [LEN_W-1:0] len;
		logic             has_grp;
		logic [7:0]       b0;
		logic [7:0]       b1;
		logic [7:0]       b2;
		logic             has_cr;
		logic [SUM_W-1:0] checksum;
	} job_t;

	function automatic logic [CHAR_W-1:0] six_to_char(input logic [5:0] v);
		return (v == 6'd0) ? ZERO_CHAR : ({1'b0, v} + CHAR_OFFSET);
	endfunction

endpackage

/* sv/uuenc_front.sv */
// front part: accepts bytes, tracks line and group state and the checksum
// builds one output job per item that yields characters; uses uuenc_pkg
module uuenc_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  uuenc_pkg::in_item_t        item,
	output logic                       push,
	output uuenc_pkg::job_t            job
);

	logic [uuenc_pkg::LEN_W-1:0] line_count_q;
	logic [uuenc_pkg::LEN_W-1:0] line_total_q;
	logic [15:0]                 group_hold_q;
	logic [1:0]                  group_pos_q;
	logic [uuenc_pkg::SUM_W-1:0] byte_sum_q;

	logic                        first;
	logic [uuenc_pkg::LEN_W-1:0] len_sat;
	logic [uuenc_pkg::LEN_W-1:0] total;
	logic [1:0]                  pos;
	logic [15:0]                 hold;
	logic [uuenc_pkg::LEN_W-1:0] cnt_n;
	logic                        line_end;
	logic [uuenc_pkg::SUM_W-1:0] sum_n;
	logic                        encode;

	always_comb begin
		encode = item.func == uuenc_pkg::FUNC_ENCODE;
		first = line_count_q == '0;
		if (item.line_length == '0) begin
			len_sat = uuenc_pkg::LEN_W'(1);
		end else if (item.line_length > uuenc_pkg::LEN_W'(uuenc_pkg::MAX_LINE_BYTES)) begin
			len_sat = uuenc_pkg::LEN_W'(uuenc_pkg::MAX_LINE_BYTES);
		end else begin
			len_sat = item.line_length;
		end
		total = first ? len_sat : line_total_q;
		pos = first ? 2'd0 : group_pos_q;
		hold = first ? 16'd0 : group_hold_q;
		cnt_n = line_count_q + uuenc_pkg::LEN_W'(1);
		line_end = cnt_n >= total;
		sum_n = byte_sum_q + {8'd0, item.data_byte};

		job.has_len = first;
		job.len = total;
		job.has_grp = (pos == 2'd2) || line_end;
		job.b0 = (pos == 2'd0) ? item.data_byte : hold[15:8];
		job.b1 = (pos == 2'd1) ? item.data_byte : ((pos == 2'd2) ? hold[7:0] : 8'd0);
		job.b2 = (pos == 2'd2) ? item.data_byte : 8'd0;
		job.has_cr = line_end;
		job.checksum = sum_n;
		push = accept && encode && (job.has_len || job.has_grp || job.has_cr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q <= '0;
			line_total_q <= '0;
			group_hold_q <= '0;
			group_pos_q <= '0;
			byte_sum_q <= '0;
		end else if (accept) begin
			if (!encode) begin
				byte_sum_q <= '0;
			end else begin
				byte_sum_q <= sum_n;
				if (line_end) begin
					line_count_q <= '0;
					line_total_q <= '0;
					group_hold_q <= '0;
					group_pos_q <= '0;
				end else begin
					line_count_q <= cnt_n;
					line_total_q <= total;
					case (pos)
						2'd0: begin
							group_hold_q <= {item.data_byte, 8'd0};
							group_pos_q <= 2'd1;
						end
						2'd1: begin
							group_hold_q <= {hold[15:8], item.data_byte};
							group_pos_q <= 2'd2;
						end
						default: begin
							group_hold_q <= '0;
							group_pos_q <= 2'd0;
						end
					endcase
				end
			end
		end
	end

	a_open_line_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		line_count_q == '0 || line_count_q < line_total_q)
		else $error("open line count reached its total");

endmodule

/* sv/uuenc_queue.sv */
// short job queue between the front and back parts
// register array with read and write pointers; uses uuenc_pkg
module uuenc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  uuenc_pkg::job_t     wr_job,
	input  logic                pop,
	output logic                full,
	output logic                head_valid,
	output uuenc_pkg::job_t     head
);

	uuenc_pkg::job_t          mem_q [uuenc_pkg::QDEPTH];
	logic [uuenc_pkg::QAW-1:0] wr_ptr_q;
	logic [uuenc_pkg::QAW-1:0] rd_ptr_q;
	logic [uuenc_pkg::QAW:0]   count_q;

	assign full = count_q == (uuenc_pkg::QAW+1)'(uuenc_pkg::QDEPTH);
	assign head_valid = count_q != '0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + uuenc_pkg::QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + uuenc_pkg::QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (uuenc_pkg::QAW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (uuenc_pkg::QAW+1)'(1);
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (uuenc_pkg::QAW+1)'(uuenc_pkg::QDEPTH))
		else $error("queue count overflow");

endmodule

/* sv/uuenc_back.sv */
// back part: steps through one job's characters into the output register
// one character per cycle while char_stall is low; uses uuenc_pkg
module uuenc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  uuenc_pkg::job_t       head,
	output logic                  pop,
	output logic                  char_valid,
	input  logic                  char_stall,
	output uuenc_pkg::out_item_t  char_item
);

	logic [uuenc_pkg::NSTEP-1:0]  done_q;
	logic                         out_valid_q;
	uuenc_pkg::out_item_t         out_q;

	logic [uuenc_pkg::NSTEP-1:0]  mask;
	logic [uuenc_pkg::NSTEP-1:0]  rem;
	logic [uuenc_pkg::NSTEP-1:0]  cur_bit;
	logic [uuenc_pkg::STEP_W-1:0] cur;
	logic                         last;
	logic                         adv;
	logic                         emit;
	logic [uuenc_pkg::CHAR_W-1:0] ch;

	always_comb begin
		mask = {head.has_cr, {4{head.has_grp}}, head.has_len};
		rem = mask & ~done_q;
		cur = '0;
		for (int i = uuenc_pkg::NSTEP - 1; i >= 0; i--) begin
			if (rem[i]) begin
				cur = uuenc_pkg::STEP_W'(i);
			end
		end
		cur_bit = uuenc_pkg::NSTEP'(1) << cur;
		last = (rem & ~cur_bit) == '0;
		adv = !out_valid_q || !char_stall;
		emit = head_valid && adv;
		pop = emit && last;
		case (cur)
			uuenc_pkg::STEP_LEN: ch = {1'b0, head.len} + uuenc_pkg::CHAR_OFFSET;
			uuenc_pkg::STEP_G0:  ch = uuenc_pkg::six_to_char(head.b0[7:2]);
			uuenc_pkg::STEP_G1:  ch = uuenc_pkg::six_to_char({head.b0[1:0], head.b1[7:4]});
			uuenc_pkg::STEP_G2:  ch = uuenc_pkg::six_to_char({head.b1[3:0], head.b2[7:6]});
			uuenc_pkg::STEP_G3:  ch = uuenc_pkg::six_to_char(head.b2[5:0]);
			uuenc_pkg::STEP_CR:  ch = uuenc_pkg::CR_CHAR;
			default:             ch = uuenc_pkg::CR_CHAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				done_q <= last ? '0 : (done_q | cur_bit);
			end else if (!char_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.char_code <= ch;
			out_q.last_in_run <= last;
			out_q.checksum <= head.checksum;
		end
	end

	assign char_valid = out_valid_q;
	assign char_item = out_q;

	a_head_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (rem != '0))
		else $error("queued job with no characters left");
	a_emit_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("emitted character lost");

endmodule

/* sv/uuencode_line_encoder_checksum_top.sv */
// uuencode line encoder with running 16-bit byte checksum, top level
// depends on uuenc_pkg, uuenc_front, uuenc_queue, uuenc_back
//
// byte channel: byte_valid/byte_stall/byte_item. func clears the checksum or
// encodes data_byte; line_length is taken on the first byte of each line.
// char channel: char_valid/char_stall/char_item, one character per transaction,
// last_in_run marks the final character caused by an input transaction.
// with an empty queue a byte's job is first written into the job queue, then its
// first character is registered in the output register and shown on char_valid;
// bytes that start no line, finish no group and end no line give none.
// throughput: one byte per cycle into a four-entry job queue while it is not full;
// the output register issues one character per cycle while char_stall is low,
// and a line of n bytes gives 4*ceil(n/3)+2 characters on the char side.
// byte_stall rises only when the job queue is full.
// when char_stall is high the output register holds its character, the back
// part waits and the queue fills; bytes keep being taken until it is full.
// reset (arst_n low) empties the queue, drops any pending character, closes
// the open line and zeroes the checksum.
module uuencode_line_encoder_checksum_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  uuenc_pkg::in_item_t   byte_item,
	output logic                  char_valid,
	input  logic                  char_stall,
	output uuenc_pkg::out_item_t  char_item
);

	logic            accept;
	logic            push;
	logic            pop;
	logic            full;
	logic            head_valid;
	uuenc_pkg::job_t wr_job;
	uuenc_pkg::job_t head;

	assign byte_stall = full;
	assign accept = byte_valid && !byte_stall;

	uuenc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (byte_item),
		.push   (push),
		.job    (wr_job)
	);

	uuenc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_job     (wr_job),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	uuenc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item)
	);

endmodule
